[rtl/cpfm_pkg.sv]
// Shared types and constants for the clock page frame manager.
// Depends on nothing; used by the controller, datapath and top level.
package cpfm_pkg;

	localparam int NumFramesDefault = 16;
	localparam int FileW = 16;
	localparam int PageW = 32;
	localparam int PinW = 16;
	localparam logic [PinW-1:0] PinMax = '1;

	localparam logic [1:0] FUNC_READ = 2'd0;
	localparam logic [1:0] FUNC_ALLOC = 2'd1;
	localparam logic [1:0] FUNC_UNPIN = 2'd2;
	localparam logic [1:0] FUNC_DISPOSE = 2'd3;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EXCEEDED = 2'd1;
	localparam logic [1:0] STAT_NOT_PINNED = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [FileW-1:0] file_id;
		logic [PageW-1:0] page_no;
		logic mark_dirty;
	} req_t;

	typedef struct packed {
		logic [3:0] frame;
		logic hit;
		logic [1:0] status;
		logic fetch;
		logic writeback;
		logic [FileW-1:0] victim_file;
		logic [PageW-1:0] victim_page;
		logic delete_page;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic look_step;
		logic look_done;
		logic sweep_start;
		logic sweep_step;
		logic finish;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic look_last;
		logic sweep_end;
	} sts_t;

endpackage

[rtl/clock_page_frame_manager_unit.sv]
// Top level of the clock page frame manager.
// Depends on cpfm_pkg, cpfm_ctrl and cpfm_dp.

// Each request runs the lookup scan over the frame table, then the decide
// and done states; a read or allocate that misses also runs the clock
// sweep between them, which clears the reference bits of frames that it
// passes. The result is then held on the output register; the next request
// is taken once it leaves.
module clock_page_frame_manager_unit #(
	parameter int NumFrames = cpfm_pkg::NumFramesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cpfm_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output cpfm_pkg::rsp_t out_data
);

	cpfm_pkg::cmd_t cmd;
	cpfm_pkg::sts_t sts;
	logic need_sweep;

	// Sequencer.
	cpfm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .need_sweep(need_sweep),
		.sts(sts), .cmd(cmd)
	);

	// Frame table and sweep datapath.
	cpfm_dp #(.NumFrames(NumFrames)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .sts(sts),
		.need_sweep(need_sweep), .rsp(out_data)
	);

endmodule

[rtl/cpfm_ctrl.sv]
// Controller state machine of the clock page frame manager.
// Depends on cpfm_pkg; drives the datapath through cmd_t and reads sts_t.
module cpfm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic need_sweep,
	input  cpfm_pkg::sts_t sts,
	output cpfm_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic out_valid_q;
	logic take;

	// A new request enters only when idle and no result waits.
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign take = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.load = take;
		case (state_q)
			ST_LOOK: begin
				cmd.look_step = 1'b1;
				cmd.look_done = sts.look_last;
			end
			ST_DECIDE: begin
				cmd.sweep_start = need_sweep;
				cmd.finish = !need_sweep;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				cmd.finish = sts.sweep_end;
			end
			default: ;
		endcase
	end

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (take) state_q <= ST_LOOK;
				ST_LOOK: if (sts.look_last) state_q <= ST_DECIDE;
				ST_DECIDE: if (need_sweep) state_q <= ST_SWEEP;
					else state_q <= ST_DONE;
				ST_SWEEP: if (sts.sweep_end) state_q <= ST_DONE;
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("request accepted while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid)
		else $error("finished request did not raise a result");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_LOOK))
		else $error("load did not start the lookup");

endmodule

[rtl/cpfm_dp.sv]
// Datapath of the clock page frame manager: frame table, lookup scan, sweep.
// Depends on cpfm_pkg; sequenced by cpfm_ctrl.
module cpfm_dp #(
	parameter int NumFrames = cpfm_pkg::NumFramesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  cpfm_pkg::req_t req,
	input  cpfm_pkg::cmd_t cmd,
	output cpfm_pkg::sts_t sts,
	output logic need_sweep,
	output cpfm_pkg::rsp_t rsp
);

	localparam int IdxW = (NumFrames > 1) ? $clog2(NumFrames) : 1;
	localparam int CntW = $clog2(NumFrames + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NumFrames - 1);

	logic [NumFrames-1:0] valid_q, ref_q, dirty_q;
	logic [cpfm_pkg::PinW-1:0] pin_q [NumFrames];
	logic [cpfm_pkg::FileW-1:0] ftag_q [NumFrames];
	logic [cpfm_pkg::PageW-1:0] ptag_q [NumFrames];
	logic [IdxW-1:0] hand_q, scan_q, hit_idx_q;
	logic found_q;
	logic [CntW-1:0] pinned_q;
	cpfm_pkg::req_t req_q;
	cpfm_pkg::rsp_t rsp_q;

	logic match;
	logic [IdxW-1:0] nxt;
	logic is_rd;

	assign is_rd = req_q.func inside {cpfm_pkg::FUNC_READ, cpfm_pkg::FUNC_ALLOC};
	assign match = valid_q[scan_q] && ftag_q[scan_q] == req_q.file_id
		&& ptag_q[scan_q] == req_q.page_no;
	assign sts.look_last = (scan_q == LastIdx);
	assign need_sweep = is_rd && !found_q;
	assign nxt = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
	// The sweep ends on an invalid frame, an unpinned victim, or full pinning.
	assign sts.sweep_end = !valid_q[nxt] || (!ref_q[nxt] && (pin_q[nxt] == '0
		|| pinned_q == CntW'(NumFrames - 1)));
	assign rsp = rsp_q;

	// Tags carry no reset; they are only read for valid frames.
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.sweep_step && sts.sweep_end && !(valid_q[nxt] && pin_q[nxt] != '0)) begin
			ftag_q[nxt] <= req_q.file_id;
			ptag_q[nxt] <= req_q.page_no;
		end
	end

	// Frame state, hand and result build-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < NumFrames; i++) pin_q[i] <= '0;
			hand_q <= LastIdx;
			scan_q <= '0;
			hit_idx_q <= '0;
			found_q <= 1'b0;
			pinned_q <= '0;
			rsp_q <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				found_q <= 1'b0;
				rsp_q <= '0;
			end
			if (cmd.look_step) begin
				if (match) begin
					found_q <= 1'b1;
					hit_idx_q <= scan_q;
				end
				if (!cmd.look_done) scan_q <= scan_q + 1'b1;
			end
			if (cmd.sweep_start) pinned_q <= '0;
			if (cmd.sweep_step) begin
				hand_q <= nxt;
				if (!valid_q[nxt] || (!ref_q[nxt] && pin_q[nxt] == '0)) begin
					if (valid_q[nxt] && dirty_q[nxt]) begin
						rsp_q.writeback <= 1'b1;
						rsp_q.victim_file <= ftag_q[nxt];
						rsp_q.victim_page <= ptag_q[nxt];
					end
					valid_q[nxt] <= 1'b1;
					ref_q[nxt] <= 1'b1;
					dirty_q[nxt] <= 1'b0;
					pin_q[nxt] <= cpfm_pkg::PinW'(1);
					rsp_q.frame <= 4'(nxt);
					rsp_q.fetch <= 1'b1;
				end else if (ref_q[nxt]) begin
					ref_q[nxt] <= 1'b0;
				end else begin
					pinned_q <= pinned_q + 1'b1;
					if (sts.sweep_end) rsp_q.status <= cpfm_pkg::STAT_EXCEEDED;
				end
			end
			// Non-sweep outcomes are settled in the decide state.
			if (cmd.finish && !cmd.sweep_step) begin
				rsp_q.delete_page <= (req_q.func == cpfm_pkg::FUNC_DISPOSE);
				if (found_q) begin
					rsp_q.frame <= 4'(hit_idx_q);
					rsp_q.hit <= 1'b1;
					case (req_q.func)
						cpfm_pkg::FUNC_READ, cpfm_pkg::FUNC_ALLOC: begin
							ref_q[hit_idx_q] <= 1'b1;
							if (pin_q[hit_idx_q] != cpfm_pkg::PinMax)
								pin_q[hit_idx_q] <= pin_q[hit_idx_q] + 1'b1;
						end
						cpfm_pkg::FUNC_UNPIN: begin
							if (pin_q[hit_idx_q] != '0) begin
								pin_q[hit_idx_q] <= pin_q[hit_idx_q] - 1'b1;
								if (req_q.mark_dirty) dirty_q[hit_idx_q] <= 1'b1;
							end else begin
								rsp_q.status <= cpfm_pkg::STAT_NOT_PINNED;
							end
						end
						default: begin
							valid_q[hit_idx_q] <= 1'b0;
							ref_q[hit_idx_q] <= 1'b0;
							dirty_q[hit_idx_q] <= 1'b0;
							pin_q[hit_idx_q] <= '0;
						end
					endcase
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |=> (hand_q == $past(nxt)))
		else $error("clock hand did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_step && !valid_q[nxt]) |=> rsp_q.fetch)
		else $error("free frame not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_start |-> !found_q)
		else $error("sweep started on a hit");

endmodule
